@@ rtl/ssl_pkg.sv @@
// Shared types and constants for the sorted set store.
package ssl_pkg;

   localparam int KEY_W        = 16;
   localparam int OP_W         = 2;
   localparam int CNT_OUT_W    = 7;
   localparam int CAPACITY_DEF = 64;

   typedef enum logic [OP_W-1:0] {
      OP_MEMBER = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   // Where an operation stands as it walks down the chain.
   typedef enum logic [1:0] {
      MODE_SEEK,
      MODE_SHIFT_R,
      MODE_SHIFT_L,
      MODE_DONE
   } wave_mode_type;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic                 success;
      logic                 full_reject;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

   // Operation token handed from cell to cell; key is the search key,
   // then the displaced key during an insert shift.
   typedef struct packed {
      logic             active;
      wave_mode_type    mode;
      logic [OP_W-1:0]  opcode;
      logic [KEY_W-1:0] key;
      logic             full;
      logic             success;
      logic             full_reject;
   } wave_type;

endpackage

@@ rtl/ssl_cell.sv @@
// One slot of the sorted store: a key register and the local step of the operation token.
module ssl_cell
   import ssl_pkg::*;
#(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] count_i,
   input  wave_type         wave_i,
   output wave_type         wave_o,
   input  logic [KEY_W-1:0] right_key_i,
   input  logic             right_valid_i,
   output logic [KEY_W-1:0] key_o,
   output logic             valid_o
);

   wave_type         wave_ff;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             valid;
   logic             lt;
   logic             eq;

   // slot holds a key when it lies below the fill count
   assign valid   = CNT_W'(INDEX) < count_i;
   assign lt      = valid && (key_ff < wave_ff.key);
   assign eq      = valid && (key_ff == wave_ff.key);
   assign key_o   = key_ff;
   assign valid_o = valid;

   always_comb begin
      key_in = key_ff;
      wave_o = wave_ff;
      if (wave_ff.active) begin
         case (wave_ff.mode)
            MODE_SEEK: begin
               if (!lt) begin
                  case (wave_ff.opcode)
                     OP_MEMBER: begin
                        wave_o.success = eq;
                        wave_o.mode    = MODE_DONE;
                     end
                     OP_INSERT: begin
                        if (eq) begin
                           wave_o.mode = MODE_DONE;
                        end else if (wave_ff.full) begin
                           wave_o.full_reject = 1'b1;
                           wave_o.mode        = MODE_DONE;
                        end else begin
                           key_in         = wave_ff.key;
                           wave_o.success = 1'b1;
                           if (valid) begin
                              wave_o.key  = key_ff;
                              wave_o.mode = MODE_SHIFT_R;
                           end else begin
                              wave_o.mode = MODE_DONE;
                           end
                        end
                     end
                     OP_DELETE: begin
                        if (eq) begin
                           key_in         = right_key_i;
                           wave_o.success = 1'b1;
                           wave_o.mode    = right_valid_i ? MODE_SHIFT_L : MODE_DONE;
                        end else begin
                           wave_o.mode = MODE_DONE;
                        end
                     end
                     default: begin
                        wave_o.mode = MODE_DONE;
                     end
                  endcase
               end
            end
            MODE_SHIFT_R: begin
               key_in = wave_ff.key;
               if (valid) begin
                  wave_o.key = key_ff;
               end else begin
                  wave_o.mode = MODE_DONE;
               end
            end
            MODE_SHIFT_L: begin
               key_in = right_key_i;
               if (!right_valid_i) begin
                  wave_o.mode = MODE_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff <= wave_i;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

@@ rtl/sorted_set_member_insert_delete_unit.sv @@
// Top level of the sorted set store: cell chain, fill count and response buffering.
//
// Holds up to CAPACITY distinct 16-bit keys in ascending order, one key per
// cell of a linear chain. Each request transaction carries an opcode (member,
// insert, delete) and a key; each yields exactly one response transaction with
// a success flag, a full-store reject flag and the entry count after the
// operation (low 7 bits). An accepted operation enters cell 0 as a token and
// moves one cell per clock: cells below the key's sorted place pass it on, the
// cell at that place resolves it, and an insert or delete then ripples the
// following keys one slot right or left as the token keeps walking. The token
// always walks the full chain, so the response is registered only once the
// token leaves the tail cell, and no new request is taken until then. Opcode 3
// changes nothing and answers with success 0. A two-entry response buffer lets
// the next request in while an earlier response still waits. The store starts
// empty after reset; no clearing pass is needed since occupancy follows from
// the fill count.
module sorted_set_member_insert_delete_unit
   import ssl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   wave_type         wave_link [CAPACITY+1];
   logic [KEY_W-1:0] cell_key  [CAPACITY+1];
   logic             cell_valid[CAPACITY+1];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff, pend_in;

   logic             req_take;
   logic             slot_free;
   wave_type         wave_last;
   rsp_type          result;

   assign req_ready = !busy_ff && !pend_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // token entering the head of the chain
   always_comb begin
      wave_link[0]             = '0;
      wave_link[0].active      = req_take;
      wave_link[0].mode        = MODE_SEEK;
      wave_link[0].opcode      = req_data.opcode;
      wave_link[0].key         = req_data.key;
      wave_link[0].full        = count_ff == CNT_W'(CAPACITY);
   end

   // nothing lies past the tail cell
   assign cell_key[CAPACITY]   = '0;
   assign cell_valid[CAPACITY] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ssl_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .count_i       (count_ff),
         .wave_i        (wave_link[i]),
         .wave_o        (wave_link[i+1]),
         .right_key_i   (cell_key[i+1]),
         .right_valid_i (cell_valid[i+1]),
         .key_o         (cell_key[i]),
         .valid_o       (cell_valid[i])
      );
   end

   assign wave_last = wave_link[CAPACITY];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (wave_last.active && wave_last.success) begin
         if (wave_last.opcode == OP_INSERT) begin
            count_in = count_ff + CNT_W'(1);
         end else if (wave_last.opcode == OP_DELETE) begin
            count_in = count_ff - CNT_W'(1);
         end
      end

      // a new key above every held key in a full store reaches the tail unresolved
      result.success     = wave_last.success;
      result.full_reject = wave_last.full_reject ||
                           (wave_last.mode == MODE_SEEK && wave_last.opcode == OP_INSERT &&
                            wave_last.full);
      result.entry_count = CNT_OUT_W'(count_in);

      busy_in = busy_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end else if (wave_last.active) begin
         busy_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (wave_last.active) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = result;
         end else begin
            pend_valid_in = 1'b1;
            pend_in       = result;
         end
      end else if (slot_free) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_in        = pend_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   // token leaves the tail only for an operation in flight
   a_exit_busy: assert property (@(posedge clock) disable iff (reset)
      wave_last.active |-> busy_ff)
      else $error("token left the chain with no operation in flight");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_pend_order: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("pending response while output register empty");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.success && rsp_ff.full_reject))
      else $error("success and full reject together");

endmodule
